FILE: hdl/efb_pkg.sv
package efb_pkg;

  localparam logic [7:0]  EscByte  = 8'h1B;
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [15:0] CrcSeed  = 16'h7E7E;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] ShortLenMax = 16'h00FF;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } efb_op_t;

  // byte slot of the frame being serialised
  typedef enum logic [9:0] {
    SLOT_FLAG0 = 10'b00_0000_0001,
    SLOT_FLAG1 = 10'b00_0000_0010,
    SLOT_DEST  = 10'b00_0000_0100,
    SLOT_HOST  = 10'b00_0000_1000,
    SLOT_STAT  = 10'b00_0001_0000,
    SLOT_LENLO = 10'b00_0010_0000,
    SLOT_LENHI = 10'b00_0100_0000,
    SLOT_DATA  = 10'b00_1000_0000,
    SLOT_CRCLO = 10'b01_0000_0000,
    SLOT_CRCHI = 10'b10_0000_0000
  } efb_slot_t;

  typedef struct packed {
    efb_op_t     operation;
    logic [7:0]  dest_addr;
    logic [7:0]  host_addr;
    logic [7:0]  status_flags;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } efb_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } efb_byte_t;

  // one byte into the CRC, MSB first, shifted in at the low end
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        carry;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      carry = c[15];
      c = {c[14:0], b[k]};
      if (carry) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/efb_sequencer.sv
module efb_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  efb_pkg::efb_item_t item,
  output logic              byte_valid,
  input  logic              byte_ready,
  output efb_pkg::efb_byte_t byte_out
);
  import efb_pkg::*;

  efb_item_t   cur;
  logic        cur_valid;
  efb_slot_t   slot;
  logic        esc_done;
  logic [15:0] crc_reg;
  logic [15:0] bytes_left;
  logic        in_frame;

  logic [7:0]  raw;
  logic        feed;
  logic        need_esc;
  logic [7:0]  emit_byte;
  logic        emit;
  logic        last_of_item;
  efb_slot_t   slot_next;
  logic        is_start;
  logic [7:0]  status_eff;
  efb_item_t   item_eff;

  always_comb begin
    raw = cur.data_byte;
    feed = 1'b1;
    unique case (slot)
      SLOT_FLAG0: begin raw = FlagByte;                 feed = 1'b0; end
      SLOT_FLAG1: begin raw = FlagByte;                 feed = 1'b0; end
      SLOT_DEST:  raw = cur.dest_addr;
      SLOT_HOST:  raw = cur.host_addr;
      SLOT_STAT:  raw = cur.status_flags;
      SLOT_LENLO: raw = cur.payload_length[7:0];
      SLOT_LENHI: raw = cur.payload_length[15:8];
      SLOT_DATA:  raw = cur.data_byte;
      SLOT_CRCLO: begin raw = crc_reg[7:0];             feed = 1'b0; end
      SLOT_CRCHI: begin raw = crc_reg[15:8];            feed = 1'b0; end
      default:    begin raw = cur.data_byte;            feed = 1'b0; end
    endcase
  end

  assign need_esc  = (slot != SLOT_FLAG0) && (slot != SLOT_FLAG1) && !esc_done &&
                     ((raw == EscByte) || (raw == FlagByte));
  assign emit_byte = need_esc ? EscByte : raw;
  assign emit      = cur_valid && byte_ready;

  // next slot once the real byte has gone out
  always_comb begin
    slot_next    = slot;
    last_of_item = 1'b0;
    unique case (slot)
      SLOT_FLAG0: slot_next = SLOT_FLAG1;
      SLOT_FLAG1: slot_next = SLOT_DEST;
      SLOT_DEST:  slot_next = SLOT_HOST;
      SLOT_HOST:  slot_next = SLOT_STAT;
      SLOT_STAT:  slot_next = SLOT_LENLO;
      SLOT_LENLO: begin
        if (cur.status_flags[0]) begin
          slot_next = SLOT_LENHI;
        end else if (bytes_left == '0) begin
          slot_next = SLOT_CRCLO;
        end else begin
          last_of_item = 1'b1;
        end
      end
      SLOT_LENHI, SLOT_DATA: begin
        if (bytes_left == '0) begin
          slot_next = SLOT_CRCLO;
        end else begin
          last_of_item = 1'b1;
        end
      end
      SLOT_CRCLO: slot_next = SLOT_CRCHI;
      SLOT_CRCHI: last_of_item = 1'b1;
      default:    last_of_item = 1'b1;
    endcase
  end

  assign item_ready = !cur_valid;
  assign is_start   = (item.operation == OP_START);
  assign status_eff = item.status_flags |
                      {7'd0, (item.payload_length > ShortLenMax)};

  // incoming item with the long-length flag folded into the status byte
  always_comb begin
    item_eff              = item;
    item_eff.status_flags = status_eff;
  end

  assign byte_valid         = cur_valid;
  assign byte_out.out_byte  = emit_byte;
  assign byte_out.frame_end = (slot == SLOT_CRCHI) && !need_esc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      slot       <= SLOT_FLAG0;
      esc_done   <= 1'b0;
      crc_reg    <= '0;
      bytes_left <= '0;
      in_frame   <= 1'b0;
    end else if (!cur_valid) begin
      if (item_valid) begin
        esc_done <= 1'b0;
        if (is_start) begin
          cur_valid  <= 1'b1;
          slot       <= SLOT_FLAG0;
          crc_reg    <= CrcSeed;
          bytes_left <= item.payload_length;
          in_frame   <= 1'b1;
        end else if (in_frame) begin
          cur_valid  <= 1'b1;
          slot       <= SLOT_DATA;
          bytes_left <= bytes_left - 16'd1;
        end
      end
    end else if (emit) begin
      if (feed) begin
        crc_reg <= crc_byte(crc_reg, emit_byte);
      end
      if (need_esc) begin
        esc_done <= 1'b1;
      end else begin
        esc_done <= 1'b0;
        slot     <= slot_next;
        if (last_of_item) begin
          cur_valid <= 1'b0;
        end
        if (slot == SLOT_CRCHI) begin
          in_frame   <= 1'b0;
          bytes_left <= '0;
        end
      end
    end
  end

  // payload fields of the held item
  always_ff @(posedge clk) begin
    if (!cur_valid && item_valid) begin
      cur <= item_eff;
    end
  end

endmodule

FILE: hdl/escaped_frame_builder_crc16_unit.sv
// Byte-stuffed frame builder with a running CRC-16 (poly 0x1021, seed 0x7E7E).
// Input stream (s_*): one transfer per item. s_tuser is the operation:
// 0 opens a frame from the header fields, 1 carries one payload byte.
// Output stream (m_*): one transfer per frame byte, m_tlast on the final
// CRC byte of each frame (never on the escape byte in front of it).
// A start item yields two 0x7E flags, dest, host, status and length bytes
// (the high length byte when status bit 0 is set, forced for lengths above
// 255), each 0x1B/0x7E after the flags preceded by 0x1B. A payload item
// yields its byte, escaped; the last payload byte, or a start item with
// length 0, also yields the CRC. Payload items outside an open frame are
// dropped silently. Each item is first loaded into the serialiser, which
// then sends its bytes one at a time, an escape byte in front of each byte
// that needs one; no item is loaded while the serialiser still holds one.
// The first output byte passes through the input buffer, the serialiser
// and the output register. A one-item input buffer lets the next item be
// taken while the current one is still being serialised.
// Reset (rst, synchronous) empties the buffer, the serialiser and the
// output register and closes any open frame. When m_tready is held low
// the output byte holds, the serialiser stops, and s_tready drops once
// the input buffer is full.
module escaped_frame_builder_crc16_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // dest_addr[7:0], host_addr[15:8], status_flags[23:16],
                                // payload_length[39:24], data_byte[47:40]
  input  logic        s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte
  output logic        m_tlast   // frame_end
);
  import efb_pkg::*;

  // input buffer
  efb_item_t buf_item;
  logic      buf_valid;
  logic      seq_ready;

  // serialiser to output register
  logic      byte_valid;
  logic      out_ready;
  efb_byte_t byte_out;

  assign s_tready = !buf_valid || seq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      buf_valid <= 1'b1;
    end else if (seq_ready) begin
      buf_valid <= 1'b0;
    end
  end

  // operation, dest, host, status, length, data from the top bit down
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_item <= efb_item_t'({s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                               s_tdata[39:24], s_tdata[47:40]});
    end
  end

  efb_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (buf_valid),
    .item_ready (seq_ready),
    .item       (buf_item),
    .byte_valid (byte_valid),
    .byte_ready (out_ready),
    .byte_out   (byte_out)
  );

  // output register: loads whenever empty or being drained
  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (byte_valid && out_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && out_ready) begin
      m_tdata <= byte_out.out_byte;
      m_tlast <= byte_out.frame_end;
    end
  end

endmodule

FILE: hdl/efb_checker.sv
module efb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // reset leaves the output empty and the input open
  a_reset_clears: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("output not empty or input blocked after reset");

  // stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output transfer changed while stalled");

  // the input buffer blocks only while something is still in flight
  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    (!s_tready) |-> $past(s_tvalid && s_tready) || $past(!s_tready))
    else $error("input blocked without an earlier transfer");

endmodule

bind escaped_frame_builder_crc16_unit efb_checker u_efb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
